// ===== rtl/sqlss_pkg.sv =====
// Shared word and job types of the SQL script statement splitter.
package sqlss_pkg;

	// One input word: a UTF-16 code unit and the end-of-script flag.
	typedef struct packed {
		logic [15:0] ch;
		logic        final_char;
	} in_word_t;

	// One result word as seen at the output ports.
	typedef struct packed {
		logic [15:0] out_char;
		logic        kind;
		logic        has_content;
		logic        run_last;
	} out_word_t;

	// One result before its position in the run is known.
	typedef struct packed {
		logic [15:0] out_char;
		logic        kind;
		logic        has_content;
	} res_entry_t;

	// All results caused by one input word, oldest in entry 0.
	typedef struct packed {
		logic [1:0] cnt;
		res_entry_t e2;
		res_entry_t e1;
		res_entry_t e0;
	} job_t;

	localparam int unsigned JOB_W = $bits(job_t);

endpackage

// ===== rtl/sqlss_fifo.sv =====
// Small register queue of jobs between the classifier and the result sequencer.
module sqlss_fifo #(
	parameter int unsigned WIDTH = 56,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             not_empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full      = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign do_wr     = wr && !full;
	assign do_rd     = rd && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	// Storage is written at the tail and needs no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	// Occupancy never goes beyond the depth.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= FULL_CNT)
		else $error("sqlss_fifo: count beyond depth");
`endif

endmodule

// ===== rtl/sqlss_front.sv =====
// Front end: scans each accepted word and builds the job of results it causes.
module sqlss_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  sqlss_pkg::in_word_t in_word,
	output logic                job_push,
	output sqlss_pkg::job_t     job
);

	// Scanner modes.
	localparam logic [2:0] M_NORMAL     = 3'd0;
	localparam logic [2:0] M_SQUOTE     = 3'd1;
	localparam logic [2:0] M_DQUOTE     = 3'd2;
	localparam logic [2:0] M_BQUOTE     = 3'd3;
	localparam logic [2:0] M_BRACKET    = 3'd4;
	localparam logic [2:0] M_LINE       = 3'd5;
	localparam logic [2:0] M_BLOCK      = 3'd6;
	localparam logic [2:0] M_BLOCK_STAR = 3'd7;

	// Held character codes.
	localparam logic [1:0] H_NONE  = 2'd0;
	localparam logic [1:0] H_MINUS = 2'd1;
	localparam logic [1:0] H_SLASH = 2'd2;

	// Characters of interest.
	localparam logic [15:0] C_NUL    = 16'h0000;
	localparam logic [15:0] C_NL     = 16'h000A;
	localparam logic [15:0] C_SPACE  = 16'h0020;
	localparam logic [15:0] C_DQUOTE = 16'h0022;
	localparam logic [15:0] C_SQUOTE = 16'h0027;
	localparam logic [15:0] C_STAR   = 16'h002A;
	localparam logic [15:0] C_MINUS  = 16'h002D;
	localparam logic [15:0] C_SLASH  = 16'h002F;
	localparam logic [15:0] C_SEMI   = 16'h003B;
	localparam logic [15:0] C_LBRACK = 16'h005B;
	localparam logic [15:0] C_RBRACK = 16'h005D;
	localparam logic [15:0] C_BTICK  = 16'h0060;

	function automatic logic is_ws(input logic [15:0] c);
		is_ws = ((c >= 16'd9) && (c <= 16'd13)) || (c == C_SPACE);
	endfunction

	logic [2:0] mode_q;
	logic [1:0] held_q;
	logic       seen_q;

	logic [2:0]  mode_d;
	logic [1:0]  held_d;
	logic        seen_d;

	// Four candidate slots: held char, main result, flushed held char, final end.
	logic        cand_en  [4];
	logic        cand_end [4];
	logic [15:0] cand_ch  [4];
	sqlss_pkg::res_entry_t ent [4];

	// Scan one character against the current mode.
	always_comb begin
		logic [15:0] c;
		logic        fin;
		logic        do_main;
		logic        ended;
		logic        seen;
		logic [2:0]  n;

		c       = in_word.ch;
		fin     = in_word.final_char;
		do_main = 1'b0;
		ended   = 1'b0;
		mode_d  = mode_q;
		held_d  = held_q;
		for (int i = 0; i < 4; i++) begin
			cand_en[i]  = 1'b0;
			cand_end[i] = 1'b0;
			cand_ch[i]  = '0;
		end

		case (mode_q)
			M_NORMAL: begin
				do_main = 1'b1;
				held_d  = H_NONE;
				if (held_q == H_MINUS) begin
					cand_en[0] = 1'b1;
					if (c == C_MINUS) begin
						cand_ch[0] = C_NL;
						mode_d     = M_LINE;
						do_main    = 1'b0;
					end else begin
						cand_ch[0] = C_MINUS;
					end
				end else if (held_q == H_SLASH) begin
					if (c == C_STAR) begin
						mode_d  = M_BLOCK;
						do_main = 1'b0;
					end else begin
						cand_en[0] = 1'b1;
						cand_ch[0] = C_SLASH;
					end
				end
				if (do_main) begin
					case (c)
						C_SEMI: begin
							cand_en[1]  = 1'b1;
							cand_end[1] = 1'b1;
							ended       = 1'b1;
						end
						C_SQUOTE: begin
							cand_en[1] = 1'b1;
							cand_ch[1] = c;
							mode_d     = M_SQUOTE;
						end
						C_DQUOTE: begin
							cand_en[1] = 1'b1;
							cand_ch[1] = c;
							mode_d     = M_DQUOTE;
						end
						C_BTICK: begin
							cand_en[1] = 1'b1;
							cand_ch[1] = c;
							mode_d     = M_BQUOTE;
						end
						C_LBRACK: begin
							cand_en[1] = 1'b1;
							cand_ch[1] = c;
							mode_d     = M_BRACKET;
						end
						C_MINUS: begin
							held_d = H_MINUS;
						end
						C_SLASH: begin
							held_d = H_SLASH;
						end
						C_NUL: begin
							cand_en[1] = 1'b1;
							cand_ch[1] = C_SPACE;
						end
						default: begin
							cand_en[1] = 1'b1;
							cand_ch[1] = c;
						end
					endcase
				end
			end
			M_SQUOTE, M_DQUOTE, M_BQUOTE, M_BRACKET: begin
				cand_en[1] = 1'b1;
				cand_ch[1] = (c == C_NUL) ? C_SPACE : c;
				if (((mode_q == M_SQUOTE) && (c == C_SQUOTE)) ||
				    ((mode_q == M_DQUOTE) && (c == C_DQUOTE)) ||
				    ((mode_q == M_BQUOTE) && (c == C_BTICK)) ||
				    ((mode_q == M_BRACKET) && (c == C_RBRACK))) begin
					mode_d = M_NORMAL;
				end
			end
			M_LINE: begin
				if (c == C_NL) begin
					mode_d = M_NORMAL;
				end
			end
			M_BLOCK: begin
				if (c == C_STAR) begin
					mode_d = M_BLOCK_STAR;
				end
			end
			default: begin
				if (c == C_SLASH) begin
					mode_d = M_NORMAL;
				end else if (c != C_STAR) begin
					mode_d = M_BLOCK;
				end
			end
		endcase

		// End of script flushes the held character and closes the statement.
		if (fin) begin
			if (held_d == H_MINUS) begin
				cand_en[2] = 1'b1;
				cand_ch[2] = C_MINUS;
			end else if (held_d == H_SLASH) begin
				cand_en[2] = 1'b1;
				cand_ch[2] = C_SLASH;
			end
			cand_en[3]  = !ended;
			cand_end[3] = 1'b1;
			mode_d      = M_NORMAL;
			held_d      = H_NONE;
		end

		// Pack the present candidates in order and track statement content.
		seen = seen_q;
		n    = '0;
		for (int i = 0; i < 4; i++) begin
			ent[i] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			if (cand_en[i]) begin
				if (cand_end[i]) begin
					ent[n[1:0]].out_char    = '0;
					ent[n[1:0]].kind        = 1'b1;
					ent[n[1:0]].has_content = seen;
					seen                    = 1'b0;
				end else begin
					ent[n[1:0]].out_char    = cand_ch[i];
					ent[n[1:0]].kind        = 1'b0;
					ent[n[1:0]].has_content = 1'b0;
					if (!is_ws(cand_ch[i])) begin
						seen = 1'b1;
					end
				end
				n = n + 3'd1;
			end
		end
		seen_d   = fin ? 1'b0 : seen;
		job.cnt  = n[1:0];
		job.e0   = ent[0];
		job.e1   = ent[1];
		job.e2   = ent[2];
		job_push = take && (n != 3'd0);
	end

	// Scanner state advances on each accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			held_q <= H_NONE;
			seen_q <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d;
			held_q <= held_d;
			seen_q <= seen_d;
		end
	end

`ifndef SYNTHESIS
	// A character is only ever held back outside quotes and comments.
	assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != H_NONE) |-> (mode_q == M_NORMAL))
		else $error("sqlss_front: held character outside normal mode");

	// After the last character of a script the scanner is back at rest.
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_word.final_char) |=> (mode_q == M_NORMAL && held_q == H_NONE && !seen_q))
		else $error("sqlss_front: state not cleared after script end");
`endif

endmodule

// ===== rtl/sqlss_back.sv =====
// Back end: steps through the results of each job, one result word per cycle on pop.
module sqlss_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sqlss_pkg::job_t      job,
	input  logic                 job_avail,
	output logic                 job_take,
	input  logic                 pop,
	output logic                 empty,
	output sqlss_pkg::out_word_t result
);

	sqlss_pkg::job_t       job_q;
	logic                  valid_q;
	logic [1:0]            idx_q;
	logic                  last;
	logic                  done;
	sqlss_pkg::res_entry_t cur;

	assign empty    = !valid_q;
	assign last     = (idx_q == job_q.cnt - 2'd1);
	assign done     = valid_q && pop && last;
	assign job_take = job_avail && (!valid_q || done);

	// Select the current entry of the job in hand.
	always_comb begin
		case (idx_q)
			2'd0:    cur = job_q.e0;
			2'd1:    cur = job_q.e1;
			2'd2:    cur = job_q.e2;
			default: cur = '0;
		endcase
		result.out_char    = cur.out_char;
		result.kind        = cur.kind;
		result.has_content = cur.has_content;
		result.run_last    = last;
	end

	// Job payload needs no reset.
	always_ff @(posedge clk) begin
		if (job_take) begin
			job_q <= job;
		end
	end

	// Index steps on each pop and restarts with every new job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (job_take) begin
				valid_q <= 1'b1;
				idx_q   <= '0;
			end else if (done) begin
				valid_q <= 1'b0;
				idx_q   <= '0;
			end else if (valid_q && pop) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	// A job in hand always has at least one result.
	assert property (@(posedge clk) disable iff (!arst_n) valid_q |-> (job_q.cnt != 2'd0))
		else $error("sqlss_back: empty job in hand");

	// The index stays within the job.
	assert property (@(posedge clk) disable iff (!arst_n) valid_q |-> (idx_q < job_q.cnt))
		else $error("sqlss_back: index beyond job");
`endif

endmodule

// ===== rtl/sql_script_statement_splitter_core.sv =====
// Top level of the SQL script statement splitter.
//
//   Port group          Direction  Handshake           Word
//   push/full/item      in         push && !full       in_word_t (ch, final_char)
//   pop/empty/result    out        pop && !empty       out_word_t (out_char, kind,
//                                                       has_content, run_last)
//
// One character is accepted per cycle while not full; a word that causes one
// result or none leaves at the same rate while the output is popped. A word that
// causes n results gives n result words, one result word per cycle while popped;
// the job queue absorbs the difference so input keeps flowing until it fills.
// Reset clears the scanner state, the job queue and the sequencer; no sweep.
// full follows the job queue alone, and a stalled output only backs up into it.
module sql_script_statement_splitter_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  sqlss_pkg::in_word_t  item,
	output logic                 empty,
	input  logic                 pop,
	output sqlss_pkg::out_word_t result
);

	logic                                  take;
	logic                                  job_push;
	sqlss_pkg::job_t                       job_in;
	logic [sqlss_pkg::JOB_W-1:0]           job_out_bits;
	sqlss_pkg::job_t                       job_out;
	logic                                  job_avail;
	logic                                  job_take;

	assign take    = push && !full;
	assign job_out = sqlss_pkg::job_t'(job_out_bits);

	// Scanner.
	sqlss_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.in_word  (item),
		.job_push (job_push),
		.job      (job_in)
	);

	// Job queue.
	sqlss_fifo #(
		.WIDTH (sqlss_pkg::JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (job_push),
		.wr_data   (job_in),
		.rd        (job_take),
		.rd_data   (job_out_bits),
		.full      (full),
		.not_empty (job_avail)
	);

	// Result sequencer.
	sqlss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.job_avail (job_avail),
		.job_take  (job_take),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule
